/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the top-level RTL file of the overlap test.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlap test: implication violated");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("overlap test: forbidden condition seen");

`endif

/* hdl/ppot_pkg.sv */
// ----------------------------------------------------------------------------
// ppot_pkg
// Shared codes and fixed field widths of the primitive pair overlap test.
// ----------------------------------------------------------------------------
package ppot_pkg;

    localparam int MODE_W     = 3;
    localparam int RADIUS_W   = 15;
    localparam int POS_W      = 48;
    localparam int ROT_W      = 64;
    localparam int HALF_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Test selection codes.
    localparam logic [MODE_W-1:0] MODE_SPHERE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AABB    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OBB     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CAP_SPH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CAP_CAP = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BOX_SPH = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNUSED6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED7 = 3'd7;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_A   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_B   = 3'd6;

    // Register stages from the input register to the separating axis verdict.
    localparam int SAT_STAGES  = 8;
    // Register stages from the input register to the simple-shape verdict.
    localparam int PRIM_STAGES = 3;
    // Accept edge to the edge at which the result is taken.
    localparam int LATENCY     = SAT_STAGES + 2;

endpackage

/* hdl/ppot_axes.sv */
// ----------------------------------------------------------------------------
// ppot_axes
// Quaternion to rotation axes: products in one stage, rounded and clamped
// axis rows in the next.
// ----------------------------------------------------------------------------
module ppot_axes #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic [ppot_pkg::ROT_W-1:0]    i_rot,
    output logic signed [QUAT_FRAC_BITS+1:0] o_axis [3][3]
);
    localparam int QB = QUAT_FRAC_BITS + 2;
    localparam int PW = 2 * QB;
    localparam int MW = 2 * QUAT_FRAC_BITS + 6;
    localparam int AW = QUAT_FRAC_BITS + 2;
    localparam logic signed [MW-1:0] Unit_Sq =
        {{(MW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);
    localparam logic signed [MW-1:0] Unit =
        {{(MW-1){1'b0}}, 1'b1} << QUAT_FRAC_BITS;
    localparam logic signed [MW-1:0] Half =
        {{(MW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

    logic signed [QB-1:0] qx, qy, qz, qw;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [MW-1:0] m [3][3];

    assign qx = $signed(i_rot[0*QB +: QB]);
    assign qy = $signed(i_rot[1*QB +: QB]);
    assign qz = $signed(i_rot[2*QB +: QB]);
    assign qw = $signed(i_rot[3*QB +: QB]);

    function automatic logic signed [AW-1:0] fix_axis(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] rnd;
        rnd = (v + Half) >>> QUAT_FRAC_BITS;
        if (rnd > Unit) begin
            rnd = Unit;
        end else if (rnd < -Unit) begin
            rnd = -Unit;
        end
        return AW'(rnd);
    endfunction

    always_ff @(posedge i_clk) begin
        r_xx <= qx * qx;
        r_yy <= qy * qy;
        r_zz <= qz * qz;
        r_xy <= qx * qy;
        r_xz <= qx * qz;
        r_yz <= qy * qz;
        r_wx <= qw * qx;
        r_wy <= qw * qy;
        r_wz <= qw * qz;
    end

    always_comb begin
        m[0][0] = Unit_Sq - ((MW'(r_yy) + MW'(r_zz)) <<< 1);
        m[0][1] = (MW'(r_xy) + MW'(r_wz)) <<< 1;
        m[0][2] = (MW'(r_xz) - MW'(r_wy)) <<< 1;
        m[1][0] = (MW'(r_xy) - MW'(r_wz)) <<< 1;
        m[1][1] = Unit_Sq - ((MW'(r_xx) + MW'(r_zz)) <<< 1);
        m[1][2] = (MW'(r_yz) + MW'(r_wx)) <<< 1;
        m[2][0] = (MW'(r_xz) + MW'(r_wy)) <<< 1;
        m[2][1] = (MW'(r_yz) - MW'(r_wx)) <<< 1;
        m[2][2] = Unit_Sq - ((MW'(r_xx) + MW'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_axis[r][c] <= fix_axis(m[r][c]);
            end
        end
    end

endmodule

/* hdl/ppot_sat.sv */
// ----------------------------------------------------------------------------
// ppot_sat
// Oriented box separating axis test over 15 axes, eight register stages
// from the input register to the verdict.
// ----------------------------------------------------------------------------
module ppot_sat #(
    parameter int COORD_BITS     = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic [ppot_pkg::ROT_W-1:0]    i_rot_a,
    input  logic [ppot_pkg::ROT_W-1:0]    i_rot_b,
    input  logic signed [COORD_BITS:0]    i_t  [3],
    input  logic [COORD_BITS-1:0]         i_ea [3],
    input  logic [COORD_BITS-1:0]         i_eb [3],
    output logic                          o_hit
);
    localparam int Q   = QUAT_FRAC_BITS;
    localparam int C   = COORD_BITS;
    localparam int AW  = Q + 2;
    localparam int TW  = C + 1;
    localparam int CRW = Q + 3;
    localparam int MAW = 2 * Q + 2;
    localparam int TAW = C + Q + 2;
    localparam int TCW = C + Q + 3;
    localparam int DAW = 2 * Q + 3;
    localparam int FW  = C + 2 * Q + 4;
    localparam int XW  = C + 2 * Q + 5;
    localparam int VW  = (TW > AW) ? TW : AW;
    localparam int PMW = 2 * AW;
    localparam int PTW = TW + AW;
    localparam int CW  = 2 * AW + 1;
    localparam int XPW = VW + CRW;
    localparam longint Eps_Val = (longint'(1) << (2 * QUAT_FRAC_BITS)) / 10000;
    localparam logic signed [CW-1:0] Cross_Eps = CW'(Eps_Val);
    localparam logic signed [CW-1:0] Half = {{(CW-1){1'b0}}, 1'b1} << (Q - 1);
    localparam int NXT  [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    logic signed [AW-1:0]  w_a [3][3];
    logic signed [AW-1:0]  w_b [3][3];

    // Stage 1 to 4 alignment of translation and axes.
    logic signed [TW-1:0]  r_t1 [3], r_t2 [3], r_t3 [3], r_t4 [3];
    logic signed [AW-1:0]  r_a3 [3][3], r_b3 [3][3], r_a4 [3][3], r_b4 [3][3];

    // Stage 3: products.
    logic signed [PMW-1:0] r_pm  [3][3][3];
    logic signed [PTW-1:0] r_pta [3][3], r_ptb [3][3];
    logic signed [PMW-1:0] r_pc0 [3][3][3], r_pc1 [3][3][3];

    // Stage 4: sums, magnitudes and rounded cross axes.
    logic signed [PMW+1:0] w_m  [3][3];
    logic signed [PTW+1:0] w_ta [3], w_tb [3];
    logic signed [CW-1:0]  w_c  [3][3][3];
    logic signed [CW-1:0]  w_cr [3][3][3];
    logic [MAW-1:0]        r_mabs [3][3];
    logic [TAW-1:0]        r_tabs_a [3], r_tabs_b [3];
    logic signed [CRW-1:0] r_cr [3][3][3];
    logic [8:0]            r_skip4, r_skip5, r_skip6, r_skip7;

    // Stage 5: weighted face terms and cross-axis dot products.
    logic [MAW+C-1:0]      r_fa [3][3], r_fb [3][3];
    logic [TAW-1:0]        r_ta5 [3], r_tb5 [3];
    logic signed [VW-1:0]  w_vec [3][3][5][3];
    logic signed [XPW-1:0] r_xp  [3][3][5][3];

    // Stage 6: face verdicts and cross-axis dot magnitudes.
    logic [FW-1:0]         w_flhs [6], w_frhs [6];
    logic signed [XPW+1:0] w_xs [3][3][5];
    logic [5:0]            r_fsep6, r_fsep7;
    logic [TCW-1:0]        r_xdt [3][3];
    logic [DAW-1:0]        r_xdv [3][3][4];

    // Stage 7: weighted cross-axis terms.
    logic [XW-1:0]         r_xl [3][3];
    logic [DAW+C-1:0]      r_xr [3][3][4];

    // Stage 8: verdict.
    logic [XW-1:0]         w_xrhs [3][3];
    logic [8:0]            w_xsep;

    ppot_axes #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_axes_a (
        .i_clk (i_clk),
        .i_rot (i_rot_a),
        .o_axis(w_a)
    );

    ppot_axes #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_axes_b (
        .i_clk (i_clk),
        .i_rot (i_rot_b),
        .o_axis(w_b)
    );

    always_ff @(posedge i_clk) begin
        r_t1 <= i_t;
        r_t2 <= r_t1;
        r_t3 <= r_t2;
        r_t4 <= r_t3;
        r_a3 <= w_a;
        r_b3 <= w_b;
        r_a4 <= r_a3;
        r_b4 <= r_b3;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            for (int n = 0; n < 3; n++) begin
                r_pta[i][n] <= r_t2[n] * w_a[i][n];
                r_ptb[i][n] <= r_t2[n] * w_b[i][n];
            end
            for (int k = 0; k < 3; k++) begin
                for (int n = 0; n < 3; n++) begin
                    r_pm[i][k][n] <= w_a[i][n] * w_b[k][n];
                end
                // Component p of A_i x B_k is A[p+1]B[p+2] - A[p+2]B[p+1].
                for (int p = 0; p < 3; p++) begin
                    r_pc0[i][k][p] <= w_a[i][NXT[p]] * w_b[k][NXT2[p]];
                    r_pc1[i][k][p] <= w_a[i][NXT2[p]] * w_b[k][NXT[p]];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ta[i] = (PTW+2)'(r_pta[i][0]) + (PTW+2)'(r_pta[i][1]) + (PTW+2)'(r_pta[i][2]);
            w_tb[i] = (PTW+2)'(r_ptb[i][0]) + (PTW+2)'(r_ptb[i][1]) + (PTW+2)'(r_ptb[i][2]);
            for (int k = 0; k < 3; k++) begin
                w_m[i][k] = (PMW+2)'(r_pm[i][k][0]) + (PMW+2)'(r_pm[i][k][1])
                          + (PMW+2)'(r_pm[i][k][2]);
                for (int p = 0; p < 3; p++) begin
                    w_c[i][k][p]  = CW'(r_pc0[i][k][p]) - CW'(r_pc1[i][k][p]);
                    w_cr[i][k][p] = (w_c[i][k][p] + Half) >>> Q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_tabs_a[i] <= TAW'((w_ta[i] < 0) ? -w_ta[i] : w_ta[i]);
            r_tabs_b[i] <= TAW'((w_tb[i] < 0) ? -w_tb[i] : w_tb[i]);
            for (int k = 0; k < 3; k++) begin
                r_mabs[i][k] <= MAW'((w_m[i][k] < 0) ? -w_m[i][k] : w_m[i][k]);
                // Nearly parallel edges give a degenerate cross axis.
                r_skip4[i*3+k] <= (w_c[i][k][0] <= Cross_Eps) && (w_c[i][k][0] >= -Cross_Eps)
                               && (w_c[i][k][1] <= Cross_Eps) && (w_c[i][k][1] >= -Cross_Eps)
                               && (w_c[i][k][2] <= Cross_Eps) && (w_c[i][k][2] >= -Cross_Eps);
                for (int p = 0; p < 3; p++) begin
                    r_cr[i][k][p] <= CRW'(w_cr[i][k][p]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int n = 0; n < 3; n++) begin
                    w_vec[i][j][0][n] = VW'(r_t4[n]);
                    w_vec[i][j][1][n] = VW'(r_a4[NXT[i]][n]);
                    w_vec[i][j][2][n] = VW'(r_a4[NXT2[i]][n]);
                    w_vec[i][j][3][n] = VW'(r_b4[NXT[j]][n]);
                    w_vec[i][j][4][n] = VW'(r_b4[NXT2[j]][n]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ta5   <= r_tabs_a;
        r_tb5   <= r_tabs_b;
        r_skip5 <= r_skip4;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_fa[i][k] <= r_mabs[i][k] * i_eb[k];
                r_fb[i][k] <= r_mabs[k][i] * i_ea[k];
            end
            for (int j = 0; j < 3; j++) begin
                for (int v = 0; v < 5; v++) begin
                    for (int n = 0; n < 3; n++) begin
                        r_xp[i][j][v][n] <= w_vec[i][j][v][n] * r_cr[i][j][n];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_flhs[i]   = FW'(r_ta5[i]) << Q;
            w_frhs[i]   = (FW'(i_ea[i]) << (2 * Q)) + FW'(r_fa[i][0])
                        + FW'(r_fa[i][1]) + FW'(r_fa[i][2]);
            w_flhs[3+i] = FW'(r_tb5[i]) << Q;
            w_frhs[3+i] = (FW'(i_eb[i]) << (2 * Q)) + FW'(r_fb[i][0])
                        + FW'(r_fb[i][1]) + FW'(r_fb[i][2]);
            for (int j = 0; j < 3; j++) begin
                for (int v = 0; v < 5; v++) begin
                    w_xs[i][j][v] = (XPW+2)'(r_xp[i][j][v][0]) + (XPW+2)'(r_xp[i][j][v][1])
                                  + (XPW+2)'(r_xp[i][j][v][2]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip6 <= r_skip5;
        for (int f = 0; f < 6; f++) begin
            r_fsep6[f] <= w_flhs[f] > w_frhs[f];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_xdt[i][j] <= TCW'((w_xs[i][j][0] < 0) ? -w_xs[i][j][0] : w_xs[i][j][0]);
                for (int v = 1; v < 5; v++) begin
                    r_xdv[i][j][v-1] <= DAW'((w_xs[i][j][v] < 0) ? -w_xs[i][j][v]
                                                                 : w_xs[i][j][v]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip7 <= r_skip6;
        r_fsep7 <= r_fsep6;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_xl[i][j]    <= XW'(r_xdt[i][j]) << Q;
                r_xr[i][j][0] <= r_xdv[i][j][0] * i_ea[NXT[i]];
                r_xr[i][j][1] <= r_xdv[i][j][1] * i_ea[NXT2[i]];
                r_xr[i][j][2] <= r_xdv[i][j][2] * i_eb[NXT[j]];
                r_xr[i][j][3] <= r_xdv[i][j][3] * i_eb[NXT2[j]];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_xrhs[i][j] = XW'(r_xr[i][j][0]) + XW'(r_xr[i][j][1])
                             + XW'(r_xr[i][j][2]) + XW'(r_xr[i][j][3]);
                w_xsep[i*3+j] = !r_skip7[i*3+j] && (r_xl[i][j] > w_xrhs[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit <= !(|r_fsep7) && !(|w_xsep);
    end

endmodule

/* hdl/ppot_prim.sv */
// ----------------------------------------------------------------------------
// ppot_prim
// Sphere, axis-aligned box, capsule and box-sphere tests: gap vector,
// squares, then the distance compare, one register stage each.
// ----------------------------------------------------------------------------
module ppot_prim #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic [ppot_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [COORD_BITS-1:0]      i_pa [3],
    input  logic signed [COORD_BITS-1:0]      i_pb [3],
    input  logic [ppot_pkg::RADIUS_W-1:0]     i_ra,
    input  logic [ppot_pkg::RADIUS_W-1:0]     i_rb,
    input  logic [ppot_pkg::RADIUS_W-1:0]     i_ha,
    input  logic [ppot_pkg::RADIUS_W-1:0]     i_hb,
    input  logic [COORD_BITS-1:0]             i_ea [3],
    input  logic [COORD_BITS-1:0]             i_eb [3],
    output logic                              o_hit
);
    localparam int GW  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 3;
    localparam int RW  = ppot_pkg::RADIUS_W + 1;
    localparam int SQW = 2 * GW;
    localparam int SW  = 2 * GW + 2;

    logic signed [GW-1:0] pa [3], pb [3], d [3], dabs [3], esum [3];
    logic signed [GW-1:0] lo5 [3], hi5 [3], cl5 [3], g5 [3], g [3];
    logic signed [GW-1:0] ha, hb, hi3, gap3, top_b, top_a, gap4;
    logic [RW-1:0]        rsel;
    logic                 use_dist, box_hit;

    logic signed [GW-1:0]  r_g1 [3];
    logic [RW-1:0]         r_r1;
    logic                  r_dist1, r_box1, r_dist2, r_box2;
    logic signed [SQW-1:0] r_sq2 [3];
    logic [2*RW-1:0]       r_rsq2;
    logic signed [SW-1:0]  w_sum;

    always_comb begin
        ha = $signed(GW'(i_ha));
        hb = $signed(GW'(i_hb));
        box_hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            pa[k]   = GW'(i_pa[k]);
            pb[k]   = GW'(i_pb[k]);
            d[k]    = pb[k] - pa[k];
            dabs[k] = (d[k] < 0) ? -d[k] : d[k];
            esum[k] = $signed(GW'(i_ea[k])) + $signed(GW'(i_eb[k]));
            if (dabs[k] > esum[k]) begin
                box_hit = 1'b0;
            end
            lo5[k] = pa[k] - $signed(GW'(i_ea[k]));
            hi5[k] = pa[k] + $signed(GW'(i_ea[k]));
            cl5[k] = pb[k];
            if (cl5[k] < lo5[k]) begin
                cl5[k] = lo5[k];
            end
            if (cl5[k] > hi5[k]) begin
                cl5[k] = hi5[k];
            end
            g5[k] = pb[k] - cl5[k];
        end

        // Capsule A against a sphere: clamp B's center onto A's segment in z.
        hi3 = pa[2] + ha;
        if (pb[2] < pa[2]) begin
            gap3 = pa[2] - pb[2];
        end else if (pb[2] > hi3) begin
            gap3 = pb[2] - hi3;
        end else begin
            gap3 = '0;
        end

        // Two capsules: vertical gap between the two segments.
        top_b = pb[2] + hb;
        top_a = pa[2] + ha;
        if (top_b < pa[2]) begin
            gap4 = pa[2] - top_b;
        end else if (top_a < pb[2]) begin
            gap4 = pb[2] - top_a;
        end else begin
            gap4 = '0;
        end

        g        = d;
        rsel     = RW'(i_ra) + RW'(i_rb);
        use_dist = 1'b0;
        case (i_mode)
            ppot_pkg::MODE_SPHERE: begin
                use_dist = 1'b1;
            end
            ppot_pkg::MODE_CAP_SPH: begin
                use_dist = 1'b1;
                g[2]     = gap3;
            end
            ppot_pkg::MODE_CAP_CAP: begin
                use_dist = 1'b1;
                g[2]     = gap4;
            end
            ppot_pkg::MODE_BOX_SPH: begin
                use_dist = 1'b1;
                g        = g5;
                rsel     = RW'(i_rb);
            end
            ppot_pkg::MODE_AABB: begin
                use_dist = 1'b0;
            end
            default: begin
                use_dist = 1'b0;
                box_hit  = 1'b0;
            end
        endcase
        // The oriented box verdict comes from the separating axis unit.
        if (i_mode == ppot_pkg::MODE_OBB) begin
            box_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1    <= g;
        r_r1    <= rsel;
        r_dist1 <= use_dist;
        r_box1  <= box_hit && (i_mode == ppot_pkg::MODE_AABB);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_sq2[k] <= r_g1[k] * r_g1[k];
        end
        r_rsq2  <= r_r1 * r_r1;
        r_dist2 <= r_dist1;
        r_box2  <= r_box1;
    end

    assign w_sum = SW'(r_sq2[0]) + SW'(r_sq2[1]) + SW'(r_sq2[2]);

    always_ff @(posedge i_clk) begin
        o_hit <= r_dist2 ? (w_sum <= $signed(SW'(r_rsq2))) : r_box2;
    end

endmodule

/* hdl/primitive_pair_overlap_test.sv */
// ----------------------------------------------------------------------------
// primitive_pair_overlap_test
// Overlap test for one pair of primitive shapes per clock.
// ----------------------------------------------------------------------------
// A shape pair is taken at a rising edge with start high and busy low; busy
// is high only while reset is applied, so one pair can enter every cycle.
// Each pair yields one beat on o_valid/o_colliding, high for exactly one
// cycle, in input order. The receiver cannot hold results off and no
// back-pressure exists anywhere in the pipeline.
// The depth of the result path is set by the oriented box path: input
// register, two quaternion stages, then three product/sum pairs of the
// separating axis unit and the output register. The other tests are padded
// to the same depth.
// Throughput: one pair per cycle, sustained.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at the
// edge; change it only while no pair is in flight. Unknown indexes are
// ignored.
// Reset (synchronous, active low) clears the configuration and valid registers
// to zero and empties the pipeline; pairs in flight are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module primitive_pair_overlap_test #(
    parameter int COORD_BITS     = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ppot_pkg::POS_W-1:0]        i_pos_a,
    input  logic [ppot_pkg::POS_W-1:0]        i_pos_b,
    input  logic [ppot_pkg::ROT_W-1:0]        i_rot_a,
    input  logic [ppot_pkg::ROT_W-1:0]        i_rot_b,
    output logic                              o_valid,
    output logic                              o_colliding,
    input  logic                              i_cfg_we,
    input  logic [ppot_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ppot_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int C     = COORD_BITS;
    localparam int EXT_W = ppot_pkg::POS_W + 3 * C;
    localparam int DLY   = ppot_pkg::SAT_STAGES - ppot_pkg::PRIM_STAGES;

    logic [ppot_pkg::MODE_W-1:0]   r_mode;
    logic [ppot_pkg::RADIUS_W-1:0] r_radius_a, r_radius_b, r_height_a, r_height_b;
    logic [ppot_pkg::HALF_W-1:0]   r_half_a, r_half_b;

    logic [ppot_pkg::POS_W-1:0]    r_pos_a0, r_pos_b0;
    logic [ppot_pkg::ROT_W-1:0]    r_rot_a0, r_rot_b0;
    logic [ppot_pkg::SAT_STAGES:0] r_vld;
    logic [ppot_pkg::SAT_STAGES:0] n_vld;
    logic [DLY-1:0]                r_prim_dly;
    logic                          r_out_vld, r_out_hit;

    logic [EXT_W-1:0]       pa_ext, pb_ext, ea_ext, eb_ext;
    logic signed [C-1:0]    w_pa [3], w_pb [3];
    logic signed [C:0]      w_t  [3];
    logic [C-1:0]           w_ea [3], w_eb [3];
    logic                   w_accept, w_sat_hit, w_prim_hit;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_radius_a <= '0;
            r_radius_b <= '0;
            r_height_a <= '0;
            r_height_b <= '0;
            r_half_a   <= '0;
            r_half_b   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppot_pkg::REG_MODE:     r_mode     <= i_cfg_data[ppot_pkg::MODE_W-1:0];
                ppot_pkg::REG_RADIUS_A: r_radius_a <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                ppot_pkg::REG_RADIUS_B: r_radius_b <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                ppot_pkg::REG_HEIGHT_A: r_height_a <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                ppot_pkg::REG_HEIGHT_B: r_height_b <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                ppot_pkg::REG_HALF_A:   r_half_a   <= i_cfg_data[ppot_pkg::HALF_W-1:0];
                ppot_pkg::REG_HALF_B:   r_half_b   <= i_cfg_data[ppot_pkg::HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: every pair is captured, the valid line tells which count.
    always_ff @(posedge i_clk) begin
        r_pos_a0 <= i_pos_a;
        r_pos_b0 <= i_pos_b;
        r_rot_a0 <= i_rot_a;
        r_rot_b0 <= i_rot_b;
    end

    // Lanes that run past the packed field read as zero.
    assign pa_ext = {{(3*C){1'b0}}, r_pos_a0};
    assign pb_ext = {{(3*C){1'b0}}, r_pos_b0};
    assign ea_ext = {{(3*C){1'b0}}, r_half_a};
    assign eb_ext = {{(3*C){1'b0}}, r_half_b};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pa[k] = $signed(pa_ext[k*C +: C]);
            w_pb[k] = $signed(pb_ext[k*C +: C]);
            w_ea[k] = ea_ext[k*C +: C];
            w_eb[k] = eb_ext[k*C +: C];
            w_t[k]  = (C+1)'(w_pb[k]) - (C+1)'(w_pa[k]);
        end
    end

    ppot_sat #(
        .COORD_BITS    (COORD_BITS),
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_sat (
        .i_clk  (i_clk),
        .i_rot_a(r_rot_a0),
        .i_rot_b(r_rot_b0),
        .i_t    (w_t),
        .i_ea   (w_ea),
        .i_eb   (w_eb),
        .o_hit  (w_sat_hit)
    );

    ppot_prim #(
        .COORD_BITS(COORD_BITS)
    ) u_prim (
        .i_clk (i_clk),
        .i_mode(r_mode),
        .i_pa  (w_pa),
        .i_pb  (w_pb),
        .i_ra  (r_radius_a),
        .i_rb  (r_radius_b),
        .i_ha  (r_height_a),
        .i_hb  (r_height_b),
        .i_ea  (w_ea),
        .i_eb  (w_eb),
        .o_hit (w_prim_hit)
    );

    assign n_vld = {r_vld[ppot_pkg::SAT_STAGES-1:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_out_vld <= r_vld[ppot_pkg::SAT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prim_dly <= {r_prim_dly[DLY-2:0], w_prim_hit};
        r_out_hit  <= (r_mode == ppot_pkg::MODE_OBB) ? w_sat_hit : r_prim_dly[DLY-1];
    end

    assign o_valid     = r_out_vld;
    assign o_colliding = r_out_hit;

    `ASSERT_IMPLY(a_result_traces_accept, i_clk, i_rst_n, o_valid,
                  $past(w_accept, ppot_pkg::LATENCY))
    `ASSERT_NEVER(a_unused_mode_no_hit, i_clk, i_rst_n,
                  o_valid && o_colliding &&
                  (r_mode == ppot_pkg::MODE_UNUSED6 || r_mode == ppot_pkg::MODE_UNUSED7))
    `ASSERT_IMPLY(a_point_spheres_meet, i_clk, i_rst_n,
                  o_valid && o_colliding && r_mode == ppot_pkg::MODE_SPHERE &&
                  r_radius_a == '0 && r_radius_b == '0,
                  $past(r_pos_a0 == r_pos_b0, ppot_pkg::LATENCY - 1))

endmodule

/* dv/primitive_pair_overlap_test_checker.sv */
// ----------------------------------------------------------------------------
// primitive_pair_overlap_test_checker
// Watches the pair and result channels, predicts the overlap flag of every
// accepted shape pair from a private copy of the registers, and compares.
// ----------------------------------------------------------------------------
module primitive_pair_overlap_test_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [ppot_pkg::POS_W-1:0]          i_pos_a,
    input  logic [ppot_pkg::POS_W-1:0]          i_pos_b,
    input  logic [ppot_pkg::ROT_W-1:0]          i_rot_a,
    input  logic [ppot_pkg::ROT_W-1:0]          i_rot_b,
    input  logic                                i_valid,
    input  logic                                i_colliding,
    input  logic                                i_cfg_we,
    input  logic [ppot_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppot_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_errors,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QF = 14;
    localparam longint QONE = 64'sd1 << QF;
    localparam longint CROSS_EPS = (64'sd1 << (2 * QF)) / 10000;

    typedef longint vec3_t [3];
    typedef longint mat3_t [3][3];

    logic [ppot_pkg::MODE_W-1:0]   mode_q;
    longint                        rad_a, rad_b, hgt_a, hgt_b;
    logic [ppot_pkg::HALF_W-1:0]   half_a, half_b;
    bit                            hit_queue[$];

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint round_q(longint v);
        return (v + QONE / 2) >>> QF;
    endfunction

    function automatic longint dot(vec3_t a, vec3_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic vec3_t coords(logic [47:0] v, bit sgn);
        vec3_t o;
        for (int k = 0; k < 3; k++) begin
            if (sgn) o[k] = longint'($signed(v[16*k +: 16]));
            else o[k] = longint'({1'b0, v[16*k +: 16]});
        end
        return o;
    endfunction

    function automatic mat3_t axes_of(logic [63:0] q);
        longint x, y, z, w, s2, v;
        mat3_t m;
        x = $signed(q[15:0]);
        y = $signed(q[31:16]);
        z = $signed(q[47:32]);
        w = $signed(q[63:48]);
        s2 = QONE * QONE;
        m[0][0] = s2 - 2 * (y * y + z * z);
        m[0][1] = 2 * (x * y + w * z);
        m[0][2] = 2 * (x * z - w * y);
        m[1][0] = 2 * (x * y - w * z);
        m[1][1] = s2 - 2 * (x * x + z * z);
        m[1][2] = 2 * (y * z + w * x);
        m[2][0] = 2 * (x * z + w * y);
        m[2][1] = 2 * (y * z - w * x);
        m[2][2] = s2 - 2 * (x * x + y * y);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                v = round_q(m[r][c]);
                if (v > QONE) v = QONE;
                if (v < -QONE) v = -QONE;
                m[r][c] = v;
            end
        end
        return m;
    endfunction

    function automatic bit boxes_overlap(vec3_t t, vec3_t ea, vec3_t eb,
                                         mat3_t am, mat3_t bm);
        longint lhs, rhs;
        vec3_t c, cr, ai, bi;
        int i1, i2, j1, j2;
        for (int i = 0; i < 3; i++) begin
            ai = am[i];
            lhs = abs64(dot(t, ai)) * QONE;
            rhs = ea[i] * QONE * QONE;
            for (int k = 0; k < 3; k++) rhs += abs64(dot(bm[k], ai)) * eb[k];
            if (lhs > rhs) return 0;
        end
        for (int i = 0; i < 3; i++) begin
            bi = bm[i];
            lhs = abs64(dot(t, bi)) * QONE;
            rhs = eb[i] * QONE * QONE;
            for (int k = 0; k < 3; k++) rhs += abs64(dot(am[k], bi)) * ea[k];
            if (lhs > rhs) return 0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                j1 = (j + 1) % 3; j2 = (j + 2) % 3;
                c[0] = am[i][1] * bm[j][2] - am[i][2] * bm[j][1];
                c[1] = am[i][2] * bm[j][0] - am[i][0] * bm[j][2];
                c[2] = am[i][0] * bm[j][1] - am[i][1] * bm[j][0];
                // Nearly parallel edge pairs give no usable axis.
                if (abs64(c[0]) <= CROSS_EPS && abs64(c[1]) <= CROSS_EPS &&
                    abs64(c[2]) <= CROSS_EPS) continue;
                for (int k = 0; k < 3; k++) cr[k] = round_q(c[k]);
                lhs = abs64(dot(t, cr)) * QONE;
                rhs = abs64(dot(am[i1], cr)) * ea[i1] + abs64(dot(am[i2], cr)) * ea[i2]
                    + abs64(dot(bm[j1], cr)) * eb[j1] + abs64(dot(bm[j2], cr)) * eb[j2];
                if (lhs > rhs) return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit predict_overlap(logic [47:0] pa_w, logic [47:0] pb_w,
                                           logic [63:0] qa, logic [63:0] qb);
        vec3_t pa, pb, ea, eb, d;
        longint reach, gap, d2, lo, hi, cl, g;
        pa = coords(pa_w, 1);
        pb = coords(pb_w, 1);
        ea = coords(half_a, 0);
        eb = coords(half_b, 0);
        for (int k = 0; k < 3; k++) d[k] = pb[k] - pa[k];
        reach = rad_a + rad_b;
        case (mode_q)
            ppot_pkg::MODE_SPHERE: return dot(d, d) <= reach * reach;
            ppot_pkg::MODE_AABB: begin
                for (int k = 0; k < 3; k++) if (abs64(d[k]) > ea[k] + eb[k]) return 0;
                return 1;
            end
            ppot_pkg::MODE_OBB: return boxes_overlap(d, ea, eb, axes_of(qa), axes_of(qb));
            ppot_pkg::MODE_CAP_SPH: begin
                lo = pa[2];
                hi = pa[2] + hgt_a;
                gap = pb[2] < lo ? lo - pb[2] : (pb[2] > hi ? pb[2] - hi : 0);
                d2 = d[0] * d[0] + d[1] * d[1] + gap * gap;
                return d2 <= reach * reach;
            end
            ppot_pkg::MODE_CAP_CAP: begin
                gap = 0;
                if (pb[2] + hgt_b < pa[2]) gap = pa[2] - (pb[2] + hgt_b);
                else if (pa[2] + hgt_a < pb[2]) gap = pb[2] - (pa[2] + hgt_a);
                d2 = d[0] * d[0] + d[1] * d[1] + gap * gap;
                return d2 <= reach * reach;
            end
            ppot_pkg::MODE_BOX_SPH: begin
                d2 = 0;
                for (int k = 0; k < 3; k++) begin
                    cl = pb[k];
                    if (cl < pa[k] - ea[k]) cl = pa[k] - ea[k];
                    if (cl > pa[k] + ea[k]) cl = pa[k] + ea[k];
                    g = pb[k] - cl;
                    d2 += g * g;
                end
                return d2 <= rad_b * rad_b;
            end
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t: overlap mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q <= '0;
            rad_a <= 0; rad_b <= 0; hgt_a <= 0; hgt_b <= 0;
            half_a <= '0; half_b <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ppot_pkg::REG_MODE:     mode_q <= i_cfg_data[ppot_pkg::MODE_W-1:0];
                    ppot_pkg::REG_RADIUS_A: rad_a <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                    ppot_pkg::REG_RADIUS_B: rad_b <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                    ppot_pkg::REG_HEIGHT_A: hgt_a <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                    ppot_pkg::REG_HEIGHT_B: hgt_b <= i_cfg_data[ppot_pkg::RADIUS_W-1:0];
                    ppot_pkg::REG_HALF_A:   half_a <= i_cfg_data;
                    ppot_pkg::REG_HALF_B:   half_b <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                hit_queue.push_back(predict_overlap(i_pos_a, i_pos_b, i_rot_a, i_rot_b));
            if (i_valid) begin
                if (hit_queue.size() == 0) report_mismatch("result beat with nothing expected");
                else begin
                    bit want;
                    want = hit_queue.pop_front();
                    if (i_colliding !== want)
                        report_mismatch($sformatf("colliding %b, expected %b",
                                                  i_colliding, want));
                end
            end
        end
        o_pending = hit_queue.size();
    end
endmodule

/* dv/primitive_pair_overlap_test_test.sv */
// ----------------------------------------------------------------------------
// primitive_pair_overlap_test_test
// Drives shape pairs through every test mode and configuration register, with
// directed corner pairs and then random pairs, and gives the verdict.
// ----------------------------------------------------------------------------
module primitive_pair_overlap_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 5000;

    logic                                clk = 0, rst_n = 0, start = 0, busy;
    logic [ppot_pkg::POS_W-1:0]          pos_a = '0, pos_b = '0;
    logic [ppot_pkg::ROT_W-1:0]          rot_a = '0, rot_b = '0;
    logic                                valid, colliding;
    logic                                cfg_we = 0;
    logic [ppot_pkg::CFG_IDX_W-1:0]      cfg_idx = '0;
    logic [ppot_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    int                                  errors, pending, idle_cycles;
    bit                                  no_gaps;

    always begin
        #6 clk = 1;
        #6 clk = 0;
    end

    primitive_pair_overlap_test dut (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_pos_a(pos_a), .i_pos_b(pos_b), .i_rot_a(rot_a), .i_rot_b(rot_b),
        .o_valid(valid), .o_colliding(colliding),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    primitive_pair_overlap_test_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_pos_a(pos_a), .i_pos_b(pos_b), .i_rot_a(rot_a), .i_rot_b(rot_b),
        .i_valid(valid), .i_colliding(colliding),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("primitive_pair_overlap_test test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [ppot_pkg::CFG_IDX_W-1:0] idx,
                             logic [ppot_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Waits for every expected beat plus the pipeline depth before a write.
    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (ppot_pkg::LATENCY + 2) @(posedge clk);
    endtask

    task automatic send_pair(logic [47:0] pa, logic [47:0] pb,
                             logic [63:0] qa, logic [63:0] qb);
        int gap;
        if (!no_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        pos_a <= pa; pos_b <= pb; rot_a <= qa; rot_b <= qb;
        do @(posedge clk); while (busy);
    endtask

    task automatic stop_sending;
        start <= 0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] near_coords(int spread);
        logic [47:0] v;
        for (int k = 0; k < 3; k++) v[16*k +: 16] = 16'($urandom_range(0, 2 * spread) - spread);
        return v;
    endfunction

    function automatic logic [63:0] rand_quat;
        logic [63:0] q;
        case ($urandom_range(0, 3))
            0: q = {16'sd16384, 48'd0};
            1: q = {$urandom, $urandom};
            default: begin
                // Random quaternions with w in 9000 to 16384 and x, y, z within +-8000, not normalized.
                for (int k = 0; k < 3; k++) q[16*k +: 16] = 16'($urandom_range(0, 16000) - 8000);
                q[63:48] = 16'($urandom_range(9000, 16384));
            end
        endcase
        return q;
    endfunction

    function automatic logic [ppot_pkg::MODE_W-1:0] pick_mode(int n);
        int m;
        m = n % 8;
        return m[ppot_pkg::MODE_W-1:0];
    endfunction

    logic [ppot_pkg::MODE_W-1:0] phase_mode;
    logic [47:0] pa, pb;

    initial begin
        no_gaps = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes with default registers, then corner shapes.
        send_pair('0, '0, '0, '0);
        send_pair({3{16'h7fff}}, {3{16'h8000}}, '1, '1);
        send_pair({3{16'h8000}}, {3{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}});
        stop_sending();
        drain();
        write_reg(ppot_pkg::REG_RADIUS_A, 48'd5);
        write_reg(ppot_pkg::REG_RADIUS_B, 48'd5);
        write_reg(3'd7, 48'h1234);  // unknown index, ignored
        send_pair('0, {16'd0, 16'd0, 16'd10}, '0, '0);  // touching spheres
        send_pair('0, {16'd0, 16'd0, 16'd11}, '0, '0);
        stop_sending();
        drain();
        write_reg(ppot_pkg::REG_MODE, ppot_pkg::MODE_UNUSED6);
        send_pair('0, '0, '0, '0);
        stop_sending();
        drain();
        write_reg(ppot_pkg::REG_MODE, ppot_pkg::MODE_UNUSED7);
        send_pair('0, '0, '0, '0);
        stop_sending();
        drain();
        write_reg(ppot_pkg::REG_MODE, ppot_pkg::MODE_OBB);
        write_reg(ppot_pkg::REG_HALF_A, {16'd10, 16'd10, 16'd10});
        write_reg(ppot_pkg::REG_HALF_B, {16'd10, 16'd10, 16'd10});
        send_pair('0, {16'd0, 16'd0, 16'd20}, {16'sd16384, 48'd0}, {16'sd16384, 48'd0});
        send_pair('0, {16'd0, 16'd0, 16'd25}, {16'sd11585, 32'd0, 16'sd11585},
                  {16'sd16384, 48'd0});
        send_pair('0, {16'd3, 16'd4, 16'd5}, {4{16'h7fff}}, '0);  // non-unit quaternion
        stop_sending();
        drain();
        write_reg(ppot_pkg::REG_MODE, ppot_pkg::MODE_BOX_SPH);
        write_reg(ppot_pkg::REG_HALF_A, '1);
        write_reg(ppot_pkg::REG_RADIUS_B, 48'h7fff);
        send_pair({3{16'h8000}}, {3{16'h7fff}}, '0, '0);
        stop_sending();
        drain();

        // Random phases, one register setting each; the last ones have no gaps.
        for (int ph = 0; ph < 22; ph++) begin
            int spread;
            no_gaps = (ph >= 20);
            phase_mode = (ph < 18) ? pick_mode(ph) : pick_mode(int'($urandom_range(0, 7)));
            spread = ($urandom_range(0, 4) == 0) ? 32767 : 200;
            write_reg(ppot_pkg::REG_MODE, phase_mode);
            write_reg(ppot_pkg::REG_RADIUS_A,
                      (ph % 7 == 0) ? 48'h7fff : 48'($urandom_range(0, 80)));
            write_reg(ppot_pkg::REG_RADIUS_B,
                      (ph % 7 == 1) ? 48'h7fff : 48'($urandom_range(0, 80)));
            write_reg(ppot_pkg::REG_HEIGHT_A,
                      (ph % 5 == 0) ? 48'h7fff : 48'($urandom_range(0, 150)));
            write_reg(ppot_pkg::REG_HEIGHT_B,
                      (ph % 5 == 1) ? 48'h7fff : 48'($urandom_range(0, 150)));
            write_reg(ppot_pkg::REG_HALF_A,
                      (ph % 6 == 0) ? '1 : {3{16'($urandom_range(0, 90))}});
            write_reg(ppot_pkg::REG_HALF_B, (ph % 6 == 3) ? '0 : {16'($urandom_range(0, 90)),
                      16'($urandom_range(0, 90)), 16'($urandom_range(0, 90))});
            for (int n = 0; n < 25; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pa = {$urandom, $urandom};
                    pb = {$urandom, $urandom};
                end else begin
                    pa = near_coords(spread);
                    for (int k = 0; k < 3; k++)
                        pb[16*k +: 16] = pa[16*k +: 16] + 16'($urandom_range(0, 400) - 200);
                end
                send_pair(pa, pb, rand_quat(), rand_quat());
            end
            stop_sending();
            drain();
        end

        if (errors == 0) begin
            $display("primitive_pair_overlap_test test passed");
        end else begin
            $display("primitive_pair_overlap_test test failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hdl
hdl/ppot_pkg.sv
hdl/ppot_axes.sv
hdl/ppot_sat.sv
hdl/ppot_prim.sv
hdl/primitive_pair_overlap_test.sv
dv/primitive_pair_overlap_test_checker.sv
dv/primitive_pair_overlap_test_test.sv
